// ===== rtl/lcps_pkg.sv =====
package lcps_pkg;

  localparam int unsigned SIZE_W = 9;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned DEF_MAX_COLUMNS = 320;
  localparam int unsigned DEF_MAX_ROWS = 320;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd240;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS = 2'd1;

  localparam logic [7:0] CMD_ROW_WINDOW = 8'h2B;
  localparam logic [7:0] CMD_COL_WINDOW = 8'h2A;
  localparam logic [7:0] CMD_WRITE_PIXELS = 8'h2C;
  localparam logic [7:0] RED_MASK = 8'hF8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;

  // Position of a byte within the 13-byte column-start sequence
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_ROW_CMD = 4'd0;
  localparam logic [IDX_W-1:0] IDX_ROW_A0H = 4'd1;
  localparam logic [IDX_W-1:0] IDX_ROW_A0L = 4'd2;
  localparam logic [IDX_W-1:0] IDX_ROW_A1H = 4'd3;
  localparam logic [IDX_W-1:0] IDX_ROW_A1L = 4'd4;
  localparam logic [IDX_W-1:0] IDX_COL_CMD = 4'd5;
  localparam logic [IDX_W-1:0] IDX_COL_A0H = 4'd6;
  localparam logic [IDX_W-1:0] IDX_COL_A0L = 4'd7;
  localparam logic [IDX_W-1:0] IDX_COL_A1H = 4'd8;
  localparam logic [IDX_W-1:0] IDX_COL_A1L = 4'd9;
  localparam logic [IDX_W-1:0] IDX_WR_CMD = 4'd10;
  localparam logic [IDX_W-1:0] IDX_PIX_HI = 4'd11;
  localparam logic [IDX_W-1:0] IDX_PIX_LO = 4'd12;

  // One classified pixel, handed from front to back
  typedef struct packed {
    logic [7:0] pix_hi;
    logic [7:0] pix_lo;
    logic header;
    logic [SIZE_W-1:0] column;
    logic [SIZE_W-1:0] row_last;
    logic done;
  } pix_desc_t;

  function automatic logic [SIZE_W-1:0] clip_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s > max) s = max;
    if (s == '0) s = SIZE_W'(1);
    return s;
  endfunction

endpackage

// ===== rtl/lcd_column_pixel_streamer.sv =====
// Path: the first output word of a pixel reaches the link side through the pixel queue,
// the back end's current-pixel register and its output register when the back end is idle.
// Throughput: one output word per cycle while m_tready allows, so two words per pixel and
// thirteen at the first pixel of a column; the byte sequencer in the back end sets this pace.
// Reset: rst clears both counters, the pixel queue and the output valid flag; sizes
// return to 240, clipped to the panel maximum.
module lcd_column_pixel_streamer
  import lcps_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // first_channel, second_channel, third_channel
  output logic m_tvalid,
  input  logic m_tready,
  output logic [7:0] m_tdata,    // link_byte
  output logic m_tlast,          // last_of_item
  output logic [1:0] m_tuser,    // is_command, frame_done
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  pix_desc_t push_desc;
  pix_desc_t head_desc;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic out_cmd;
  logic out_done;

  assign cfg_ready = 1'b1;
  assign m_tuser = {out_done, out_cmd};

  lcps_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pix_valid(s_tvalid),
    .pix_ready(s_tready),
    .pix_data(s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_desc(push_desc)
  );

  lcps_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_desc(push_desc),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .head(head_desc)
  );

  lcps_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_head(head_desc),
    .q_pop(q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte(m_tdata),
    .out_cmd(out_cmd),
    .out_last(m_tlast),
    .out_done(out_done)
  );

endmodule

// ===== rtl/lcps_front.sv =====
module lcps_front
  import lcps_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  logic [3*CHAN_W-1:0] pix_data,
  input  logic cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic q_full,
  output logic q_push,
  output pix_desc_t q_desc
);

  localparam logic [SIZE_W-1:0] MaxCol = SIZE_W'(MAX_COLUMNS);
  localparam logic [SIZE_W-1:0] MaxRow = SIZE_W'(MAX_ROWS);

  logic [SIZE_W-1:0] columns_in_use;
  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] column_index;
  logic [SIZE_W-1:0] row_index;
  logic [SIZE_W-1:0] column_index_next;
  logic [SIZE_W-1:0] row_index_next;
  logic [SIZE_W-1:0] row_inc;
  logic [SIZE_W-1:0] col_inc;
  logic col_wrap;
  logic frame_wrap;
  logic [7:0] r_ch;
  logic [7:0] g_ch;
  logic [7:0] b_ch;

  assign r_ch = pix_data[CHAN_W-1:0];
  assign g_ch = pix_data[2*CHAN_W-1:CHAN_W];
  assign b_ch = pix_data[3*CHAN_W-1:2*CHAN_W];

  assign pix_ready = !q_full;
  assign q_push = pix_valid && pix_ready;

  always_comb begin
    row_inc = row_index + SIZE_W'(1);
    col_inc = column_index + SIZE_W'(1);
    col_wrap = (row_inc >= rows_in_use) || (row_inc == '0);
    frame_wrap = col_wrap && ((col_inc >= columns_in_use) || (col_inc == '0));
    row_index_next = col_wrap ? '0 : row_inc;
    if (!col_wrap) begin
      column_index_next = column_index;
    end else if (frame_wrap) begin
      column_index_next = '0;
    end else begin
      column_index_next = col_inc;
    end
  end

  always_comb begin
    q_desc.pix_hi = (r_ch & RED_MASK) | {5'd0, g_ch[7:5]};
    q_desc.pix_lo = {g_ch[4:2], b_ch[7:3]};
    q_desc.header = (row_index == '0);
    q_desc.column = column_index;
    q_desc.row_last = rows_in_use - SIZE_W'(1);
    q_desc.done = frame_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= clip_size(SIZE_RESET, MaxCol);
      rows_in_use <= clip_size(SIZE_RESET, MaxRow);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_COLUMNS) columns_in_use <= clip_size(cfg_data, MaxCol);
      if (cfg_index == CFG_ROWS) rows_in_use <= clip_size(cfg_data, MaxRow);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index <= '0;
    end else if (q_push) begin
      column_index <= column_index_next;
      row_index <= row_index_next;
    end
  end

endmodule

// ===== rtl/lcps_queue.sv =====
module lcps_queue
  import lcps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_desc_t push_desc,
  output logic full,
  input  logic pop,
  output logic empty,
  output pix_desc_t head
);

  pix_desc_t slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0] count;

  assign full = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10: count <= count + (QUEUE_AW+1)'(1);
        2'b01: count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lcps_back.sv =====
module lcps_back
  import lcps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  pix_desc_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_byte,
  output logic out_cmd,
  output logic out_last,
  output logic out_done
);

  pix_desc_t cur;
  logic cur_valid;
  logic [IDX_W-1:0] idx;
  logic advance;
  logic emit;
  logic at_end;
  logic load;
  logic [7:0] sel_byte;
  logic sel_cmd;

  assign advance = !out_valid || out_ready;
  assign emit = cur_valid && advance;
  assign at_end = (idx == IDX_PIX_LO);
  assign load = !cur_valid || (emit && at_end);
  assign q_pop = load && !q_empty;

  always_comb begin
    sel_cmd = 1'b0;
    case (idx)
      IDX_ROW_CMD: begin
        sel_byte = CMD_ROW_WINDOW;
        sel_cmd = 1'b1;
      end
      IDX_ROW_A0H, IDX_ROW_A1H: sel_byte = {7'd0, cur.column[8]};
      IDX_ROW_A0L, IDX_ROW_A1L: sel_byte = cur.column[7:0];
      IDX_COL_CMD: begin
        sel_byte = CMD_COL_WINDOW;
        sel_cmd = 1'b1;
      end
      IDX_COL_A0H, IDX_COL_A0L: sel_byte = 8'd0;
      IDX_COL_A1H: sel_byte = {7'd0, cur.row_last[8]};
      IDX_COL_A1L: sel_byte = cur.row_last[7:0];
      IDX_WR_CMD: begin
        sel_byte = CMD_WRITE_PIXELS;
        sel_cmd = 1'b1;
      end
      IDX_PIX_HI: sel_byte = cur.pix_hi;
      IDX_PIX_LO: sel_byte = cur.pix_lo;
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      // take the next pixel, skipping the window commands mid-column
      cur_valid <= !q_empty;
      idx <= q_head.header ? IDX_ROW_CMD : IDX_PIX_HI;
    end else if (emit) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= sel_byte;
      out_cmd <= sel_cmd;
      out_last <= at_end;
      out_done <= at_end && cur.done;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import lcps_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int unsigned IDLE_PCT = 27;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_PRINTED = 40;
  localparam int unsigned RANDOM_PIXELS = 115;
  localparam int unsigned WIDE_PIXELS = 32;

  // One word on the link side
  typedef struct packed {
    logic [7:0] data;
    logic cmd;
    logic last;
    logic done;
  } link_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;     // first_channel, second_channel, third_channel
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;           // link_byte
  logic m_tlast;                 // last_of_item
  logic [1:0] m_tuser;           // is_command, frame_done
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Panel position and frame size as the block should see them
  logic [SIZE_W-1:0] col_pos = '0;
  logic [SIZE_W-1:0] row_pos = '0;
  logic [SIZE_W-1:0] col_count = SIZE_W'(240);
  logic [SIZE_W-1:0] row_count = SIZE_W'(240);

  link_word_t link_q[$];
  bit steady_flow = 1'b0;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned stall_cycles = 0;

  lcd_column_pixel_streamer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned limit);
    logic [SIZE_W-1:0] lim;
    lim = SIZE_W'(limit);
    if (v > lim) return lim;
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

  // Expected link words for one pixel, then advance row and column
  function automatic void predict_pixel(input logic [7:0] r, g, b);
    link_word_t seq[$];
    logic [SIZE_W-1:0] row_next;
    logic [SIZE_W-1:0] col_next;
    logic [SIZE_W-1:0] row_top;
    logic done;
    done = 1'b0;
    row_top = row_count - SIZE_W'(1);
    if (row_pos == '0) begin
      seq.push_back('{CMD_ROW_WINDOW, 1'b1, 1'b0, 1'b0});
      seq.push_back('{8'(col_pos >> 8), 1'b0, 1'b0, 1'b0});
      seq.push_back('{col_pos[7:0], 1'b0, 1'b0, 1'b0});
      seq.push_back('{8'(col_pos >> 8), 1'b0, 1'b0, 1'b0});
      seq.push_back('{col_pos[7:0], 1'b0, 1'b0, 1'b0});
      seq.push_back('{CMD_COL_WINDOW, 1'b1, 1'b0, 1'b0});
      seq.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      seq.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      seq.push_back('{8'(row_top >> 8), 1'b0, 1'b0, 1'b0});
      seq.push_back('{row_top[7:0], 1'b0, 1'b0, 1'b0});
      seq.push_back('{CMD_WRITE_PIXELS, 1'b1, 1'b0, 1'b0});
    end
    seq.push_back('{{r[7:3], g[7:5]}, 1'b0, 1'b0, 1'b0});
    seq.push_back('{{g[4:2], b[7:3]}, 1'b0, 1'b0, 1'b0});

    row_next = row_pos + SIZE_W'(1);
    if (row_next >= row_count || row_next == '0) begin
      row_pos = '0;
      col_next = col_pos + SIZE_W'(1);
      if (col_next >= col_count || col_next == '0) begin
        col_pos = '0;
        done = 1'b1;
      end else begin
        col_pos = col_next;
      end
    end else begin
      row_pos = row_next;
    end

    seq[seq.size()-1].last = 1'b1;
    seq[seq.size()-1].done = done;
    foreach (seq[i]) link_q.push_back(seq[i]);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return SIZE_W'($urandom_range(1, 6));
    if (roll < 88) return '0;
    return SIZE_W'($urandom_range(0, 511));
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    if (errors < MAX_PRINTED)
      $display("mismatch on %s: want %0h got %0h (word %0d)", field, want, got,
               words_checked);
    errors++;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(r, g, b);
    pixels_sent++;
  endtask

  task automatic stop_stream();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (link_q.size() != 0) @(posedge clk);
  endtask

  // Sizes change only with the pipeline empty
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [SIZE_W-1:0] value);
    stop_stream();
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_COLUMNS: col_count = fit_size(value, DEF_MAX_COLUMNS);
      CFG_ROWS: row_count = fit_size(value, DEF_MAX_ROWS);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset sizes and the color extremes, including the truncation boundaries
  task automatic test_default_size();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hF8, 8'hFC, 8'hF8);
    send_pixel(8'h07, 8'h03, 8'h07);
  endtask

  // Shrink both sizes below the current position, the row count while inside a column
  task automatic test_shrink_mid_frame();
    write_reg(CFG_ROWS, 9'd2);
    send_pixel(8'hA5, 8'h5A, 8'hC3);
    write_reg(CFG_COLUMNS, 9'd1);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'hFE, 8'h01, 8'h80);
  endtask

  // Zero, oversized and unmapped writes
  task automatic test_size_extremes();
    write_reg(CFG_COLUMNS, 9'd0);
    write_reg(CFG_ROWS, 9'd0);
    send_pixel(8'h80, 8'h40, 8'h20);
    send_pixel(8'h01, 8'h02, 8'h04);
    write_reg(CFG_NO_REG, 9'h1FF);
    send_pixel(8'h55, 8'hAA, 8'h55);
    write_reg(CFG_COLUMNS, 9'h1FF);
    write_reg(CFG_ROWS, 9'h1FF);
    send_pixel(8'h3C, 8'hC3, 8'h99);
    send_pixel(8'hC0, 8'h1F, 8'hE7);
    send_pixel(8'h7F, 8'h80, 8'h08);
  endtask

  // Random colors in bursts, sizes changed between bursts, mostly small frames
  task automatic test_random_frames();
    int unsigned target;
    int unsigned burst;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      case ($urandom_range(3))
        0: write_reg(CFG_COLUMNS, pick_size());
        1: write_reg(CFG_ROWS, pick_size());
        2: begin
          write_reg(CFG_COLUMNS, pick_size());
          write_reg(CFG_ROWS, pick_size());
        end
        default: ;
      endcase
      steady_flow = ($urandom_range(5) == 0);
      burst = $urandom_range(1, 24);
      repeat (burst) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    steady_flow = 1'b0;
  endtask

  // One-row frame at full width: a header on every pixel, no idling at all
  task automatic test_wide_frame();
    write_reg(CFG_ROWS, 9'd1);
    write_reg(CFG_COLUMNS, SIZE_W'(DEF_MAX_COLUMNS));
    steady_flow = 1'b1;
    repeat (WIDE_PIXELS) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    stop_stream();
    steady_flow = 1'b0;
  endtask

  always @(posedge clk) begin : link_monitor
    link_word_t exp_w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (link_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 32'(m_tdata));
        end else begin
          exp_w = link_q.pop_front();
          if (m_tdata !== exp_w.data)
            report_mismatch("link_byte", 32'(exp_w.data), 32'(m_tdata));
          if (m_tuser[0] !== exp_w.cmd)
            report_mismatch("is_command", 32'(exp_w.cmd), 32'(m_tuser[0]));
          if (m_tlast !== exp_w.last)
            report_mismatch("last_of_item", 32'(exp_w.last), 32'(m_tlast));
          if (m_tuser[1] !== exp_w.done)
            report_mismatch("frame_done", 32'(exp_w.done), 32'(m_tuser[1]));
          if (exp_w.done) frames_seen++;
          words_checked++;
        end
      end
      m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_size();
    test_shrink_mid_frame();
    test_size_extremes();
    test_random_frames();
    test_wide_frame();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d pixels, checked %0d link words, saw %0d frame ends",
             pixels_sent, words_checked, frames_seen);
    $display("sizes swept from zero to oversized, resized mid-frame, gap-free one-row run");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
